// ===== rtl/pcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsd_pkg
// shared widths, register indexes and constants of the point-to-conic
// first-order distance unit
// ----------------------------------------------------------------------------
package pcsd_pkg;

    // coordinate bits that carry the value, sign-extended from the top one
    localparam int COORD_WIDTH = 32;

    // stream payload widths
    localparam int S_TDATA_WIDTH = 96;
    localparam int M_TDATA_WIDTH = 48;
    localparam int COEF_WIDTH    = 32;
    localparam int CFG_ADDR_WIDTH = 3;

    // internal value widths
    localparam int ACC_WIDTH  = 97;   // algebraic sum, Q.56
    localparam int AVAL_WIDTH = 57;   // algebraic value, Q.16
    localparam int GMAG_WIDTH = 41;   // gradient magnitude, Q.16
    localparam int DEN_WIDTH  = 82;   // sum of gradient squares, Q.32
    localparam int NUM_WIDTH  = 114;  // squared algebraic value, Q.32

    // one quotient bit per divider stage
    localparam int DIV_STAGES = 48;

    // front stages, divider setup, divider stages, output register
    localparam int FRONT_STAGES = 8;
    localparam int PIPE_DEPTH   = FRONT_STAGES + 1 + DIV_STAGES + 1;

    localparam logic [M_TDATA_WIDTH-1:0] DIST_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_COEF_XX = 3'd0,
        CFG_COEF_XY = 3'd1,
        CFG_COEF_XW = 3'd2,
        CFG_COEF_YY = 3'd3,
        CFG_COEF_YW = 3'd4,
        CFG_COEF_WW = 3'd5
    } cfg_index_t;

endpackage

// ===== rtl/point_conic_sampson_distance_unit.sv =====
// ----------------------------------------------------------------------------
// point_conic_sampson_distance_unit
// streams homogeneous points and returns their first-order distance to the
// conic held in the six coefficient registers
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata: x_coord, y_coord, w_coord; tlast: in_last
//  m_*       out        tdata: distance; tuser: zero_denominator; tlast: out_last
//  cfg_*     in         write enable, register index, 32-bit data
//
//  one point enters per cycle while the result side is not stalled; a result
//  passes through 8 arithmetic stages, the divider setup stage, 48 restoring divider
//  stages (one quotient bit each) and the output register.
//  reset clears the stage valid bits and the coefficients.
//  a stalled result holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module point_conic_sampson_distance_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_coord [31:0], y_coord [63:32], w_coord [95:64]
    input  logic [pcsd_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // distance [47:0]
    output logic [pcsd_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    // zero_denominator [0]
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [pcsd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [pcsd_pkg::COEF_WIDTH-1:0]      cfg_wdata
);
    import pcsd_pkg::*;

    // coefficient registers
    logic signed [COEF_WIDTH-1:0] coef_xx_reg, coef_xy_reg, coef_xw_reg;
    logic signed [COEF_WIDTH-1:0] coef_yy_reg, coef_yw_reg, coef_ww_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_xx_reg <= '0;
            coef_xy_reg <= '0;
            coef_xw_reg <= '0;
            coef_yy_reg <= '0;
            coef_yw_reg <= '0;
            coef_ww_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_COEF_XX: coef_xx_reg <= cfg_wdata;
                CFG_COEF_XY: coef_xy_reg <= cfg_wdata;
                CFG_COEF_XW: coef_xw_reg <= cfg_wdata;
                CFG_COEF_YY: coef_yy_reg <= cfg_wdata;
                CFG_COEF_YW: coef_yw_reg <= cfg_wdata;
                CFG_COEF_WW: coef_ww_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid/last tracking
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] last_reg;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last_reg <= {last_reg[PIPE_DEPTH-2:0], s_tlast};
        end
    end

    // input coordinates, sign-extended from the used bits
    logic signed [COORD_WIDTH-1:0] x_low, y_low, w_low;
    logic signed [31:0]            x_in, y_in, w_in;

    assign x_low = s_tdata[COORD_WIDTH-1:0];
    assign y_low = s_tdata[32+COORD_WIDTH-1:32];
    assign w_low = s_tdata[64+COORD_WIDTH-1:64];
    assign x_in  = 32'(x_low);
    assign y_in  = 32'(y_low);
    assign w_in  = 32'(w_low);

    // stage 1: coordinate products and coefficient-by-coordinate terms
    logic signed [63:0] xx_reg, xy_reg, yy_reg;
    logic signed [63:0] c00x_reg, c01y_reg, c02w_reg, c01x_reg, c11y_reg, c12w_reg;
    logic signed [63:0] c02x_reg, c12y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xx_reg   <= x_in * x_in;
            xy_reg   <= x_in * y_in;
            yy_reg   <= y_in * y_in;
            c00x_reg <= coef_xx_reg * x_in;
            c01y_reg <= coef_xy_reg * y_in;
            c02w_reg <= coef_xw_reg * w_in;
            c01x_reg <= coef_xy_reg * x_in;
            c11y_reg <= coef_yy_reg * y_in;
            c12w_reg <= coef_yw_reg * w_in;
            c02x_reg <= coef_xw_reg * x_in;
            c12y_reg <= coef_yw_reg * y_in;
        end
    end

    // stage 2: split quadratic products, gradient sums, linear terms
    logic signed [63:0]         p00h_reg, p01h_reg, p11h_reg;
    logic signed [64:0]         p00l_reg, p01l_reg, p11l_reg;
    logic signed [41:0]         g1_reg, g2_reg;
    logic signed [ACC_WIDTH-1:0] lin2_reg;
    logic signed [65:0]         g1_sum, g2_sum;

    assign g1_sum = 66'(c00x_reg) + 66'(c01y_reg) + 66'(c02w_reg);
    assign g2_sum = 66'(c01x_reg) + 66'(c11y_reg) + 66'(c12w_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p00h_reg <= coef_xx_reg * $signed(xx_reg[63:32]);
            p01h_reg <= coef_xy_reg * $signed(xy_reg[63:32]);
            p11h_reg <= coef_yy_reg * $signed(yy_reg[63:32]);
            p00l_reg <= coef_xx_reg * $signed({1'b0, xx_reg[31:0]});
            p01l_reg <= coef_xy_reg * $signed({1'b0, xy_reg[31:0]});
            p11l_reg <= coef_yy_reg * $signed({1'b0, yy_reg[31:0]});
            g1_reg   <= g1_sum[65:24];
            g2_reg   <= g2_sum[65:24];
            lin2_reg <= ((ACC_WIDTH'(c02x_reg) + ACC_WIDTH'(c12y_reg)) <<< 17)
                        + (ACC_WIDTH'(coef_ww_reg) <<< 32);
        end
    end

    // stage 3: recombine quadratic terms, gradient magnitudes
    logic signed [ACC_WIDTH-1:0] t00_reg, t01_reg, t11_reg, lin3_reg;
    logic [GMAG_WIDTH-1:0]       g1m_reg, g2m_reg;
    logic signed [41:0]          g1_neg, g2_neg;

    assign g1_neg = -g1_reg;
    assign g2_neg = -g2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t00_reg  <= (ACC_WIDTH'(p00h_reg) <<< 32) + ACC_WIDTH'(p00l_reg);
            t01_reg  <= (ACC_WIDTH'(p01h_reg) <<< 32) + ACC_WIDTH'(p01l_reg);
            t11_reg  <= (ACC_WIDTH'(p11h_reg) <<< 32) + ACC_WIDTH'(p11l_reg);
            lin3_reg <= lin2_reg;
            g1m_reg  <= g1_reg[41] ? g1_neg[GMAG_WIDTH-1:0] : g1_reg[GMAG_WIDTH-1:0];
            g2m_reg  <= g2_reg[41] ? g2_neg[GMAG_WIDTH-1:0] : g2_reg[GMAG_WIDTH-1:0];
        end
    end

    // stage 4: partial sums of the algebraic value, gradient square partials
    logic signed [ACC_WIDTH-1:0] sa_reg, sb_reg;
    logic [17:0] g1hh_reg, g2hh_reg;
    logic [40:0] g1hl_reg, g2hl_reg;
    logic [63:0] g1ll_reg, g2ll_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg   <= t00_reg + t11_reg;
            sb_reg   <= (t01_reg <<< 1) + lin3_reg;
            g1hh_reg <= 18'(g1m_reg[40:32]) * 18'(g1m_reg[40:32]);
            g2hh_reg <= 18'(g2m_reg[40:32]) * 18'(g2m_reg[40:32]);
            g1hl_reg <= 41'(g1m_reg[40:32]) * 41'(g1m_reg[31:0]);
            g2hl_reg <= 41'(g2m_reg[40:32]) * 41'(g2m_reg[31:0]);
            g1ll_reg <= 64'(g1m_reg[31:0]) * 64'(g1m_reg[31:0]);
            g2ll_reg <= 64'(g2m_reg[31:0]) * 64'(g2m_reg[31:0]);
        end
    end

    // stage 5: algebraic value floored to Q.16, gradient squares
    logic signed [AVAL_WIDTH-1:0] a5_reg;
    logic [DEN_WIDTH-1:0]         g1sq_reg, g2sq_reg;
    logic signed [ACC_WIDTH-1:0]  acc_sum;

    assign acc_sum = sa_reg + sb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a5_reg   <= acc_sum[ACC_WIDTH-1:40];
            g1sq_reg <= (DEN_WIDTH'(g1hh_reg) << 64) + (DEN_WIDTH'(g1hl_reg) << 33)
                        + DEN_WIDTH'(g1ll_reg);
            g2sq_reg <= (DEN_WIDTH'(g2hh_reg) << 64) + (DEN_WIDTH'(g2hl_reg) << 33)
                        + DEN_WIDTH'(g2ll_reg);
        end
    end

    // stage 6: magnitude of the algebraic value, denominator
    logic [AVAL_WIDTH-1:0]        am_reg;
    logic [DEN_WIDTH-1:0]         den6_reg;
    logic signed [AVAL_WIDTH-1:0] a5_neg;

    assign a5_neg = -a5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            am_reg   <= a5_reg[AVAL_WIDTH-1] ? a5_neg : a5_reg;
            den6_reg <= g1sq_reg + g2sq_reg;
        end
    end

    // stage 7: numerator square partials
    logic [49:0]          ahh_reg;
    logic [56:0]          ahl_reg;
    logic [63:0]          all_reg;
    logic [DEN_WIDTH-1:0] den7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ahh_reg  <= 50'(am_reg[56:32]) * 50'(am_reg[56:32]);
            ahl_reg  <= 57'(am_reg[56:32]) * 57'(am_reg[31:0]);
            all_reg  <= 64'(am_reg[31:0]) * 64'(am_reg[31:0]);
            den7_reg <= den6_reg;
        end
    end

    // stage 8: numerator
    logic [NUM_WIDTH-1:0] num8_reg;
    logic [DEN_WIDTH-1:0] den8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            num8_reg <= (NUM_WIDTH'(ahh_reg) << 64) + (NUM_WIDTH'(ahl_reg) << 33)
                        + NUM_WIDTH'(all_reg);
            den8_reg <= den7_reg;
        end
    end

    // divider: restoring, one quotient bit per stage
    logic [DEN_WIDTH-1:0]  dv_r_reg    [0:DIV_STAGES];
    logic [DEN_WIDTH-1:0]  dv_d_reg    [0:DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_l_reg    [0:DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_q_reg    [0:DIV_STAGES];
    logic                  dv_sat_reg  [0:DIV_STAGES];
    logic                  dv_zero_reg [0:DIV_STAGES];

    // setup: quotient would reach 2^48 when the high numerator part is not below den
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_r_reg[0]    <= num8_reg[NUM_WIDTH-1:32];
            dv_d_reg[0]    <= den8_reg;
            dv_l_reg[0]    <= {num8_reg[31:0], 16'd0};
            dv_q_reg[0]    <= '0;
            dv_sat_reg[0]  <= (num8_reg[NUM_WIDTH-1:32] >= den8_reg);
            dv_zero_reg[0] <= (den8_reg == '0);
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [DEN_WIDTH:0]   trial;
        logic [DEN_WIDTH+1:0] diff;
        logic                 ge;

        // shift in the next dividend bit and try a subtract
        assign trial = {dv_r_reg[k], dv_l_reg[k][DIV_STAGES-1]};
        assign diff  = {1'b0, trial} - {2'b00, dv_d_reg[k]};
        assign ge    = !diff[DEN_WIDTH+1];

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_r_reg[k+1]    <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_l_reg[k+1]    <= {dv_l_reg[k][DIV_STAGES-2:0], 1'b0};
                dv_q_reg[k+1]    <= {dv_q_reg[k][DIV_STAGES-2:0], ge};
                dv_sat_reg[k+1]  <= dv_sat_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
            end
        end
    end

    // output register
    logic [M_TDATA_WIDTH-1:0] dist_reg;
    logic                     zero_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg <= dv_sat_reg[DIV_STAGES] ? DIST_MAX : dv_q_reg[DIV_STAGES];
            zero_reg <= dv_zero_reg[DIV_STAGES];
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = dist_reg;
    assign m_tuser  = zero_reg;
    assign m_tlast  = last_reg[PIPE_DEPTH-1];

endmodule

// ===== rtl/pcsd_checker.sv =====
// ----------------------------------------------------------------------------
// pcsd_checker
// port-level checks of the point-to-conic distance unit
// ----------------------------------------------------------------------------
module pcsd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [pcsd_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    input logic                                m_tuser
);
    import pcsd_pkg::*;

    // a stalled result transaction stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result transaction keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // zero denominator always reports the saturated distance
    a_zero_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == DIST_MAX)
        else $error("zero denominator without maximum distance");

    // input side only stalls while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input stalled without output backpressure");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind point_conic_sampson_distance_unit pcsd_checker u_pcsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/point_conic_sampson_distance_checker.sv =====
// ----------------------------------------------------------------------------
// point_conic_sampson_distance_checker
// watches the point, result and coefficient ports of the distance unit,
// predicts the distance of every accepted point from its own copy of the
// conic and compares each result in order against the oldest prediction
// ----------------------------------------------------------------------------
module point_conic_sampson_distance_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // x_coord [31:0], y_coord [63:32], w_coord [95:64]
    input  logic [pcsd_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // distance [47:0]
    input  logic [pcsd_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    // zero_denominator [0]
    input  logic                                 m_tuser,
    input  logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [pcsd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [pcsd_pkg::COEF_WIDTH-1:0]      cfg_wdata,
    output int                                   error_count,
    output int                                   results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import pcsd_pkg::*;

    typedef struct packed {
        logic [M_TDATA_WIDTH-1:0] distance;
        logic                     zero_den;
        logic                     last;
    } dist_result_t;

    // conic entries as seen by the unit
    logic signed [COEF_WIDTH-1:0] conic_xx, conic_xy, conic_xw;
    logic signed [COEF_WIDTH-1:0] conic_yy, conic_yw, conic_ww;

    dist_result_t owed_distances[$];

    assign results_owed = owed_distances.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // exact first-order distance of one point to the current conic
    function automatic dist_result_t sampson_distance(input logic signed [31:0] xc,
                                                      input logic signed [31:0] yc,
                                                      input logic signed [31:0] wc,
                                                      input logic last);
        logic signed [127:0] x, y, w, k00, k01, k02, k11, k12, k22;
        logic signed [127:0] acc, a, g1, g2;
        logic [127:0] am, g1m, g2m, num, den;
        logic [143:0] quo;
        dist_result_t r;
        x = xc;
        y = yc;
        w = wc;
        k00 = conic_xx;
        k01 = conic_xy;
        k02 = conic_xw;
        k11 = conic_yy;
        k12 = conic_yw;
        k22 = conic_ww;
        // algebraic value with unit weight, Q.56 floored to Q.16
        acc = k00 * (x * x) + ((k01 * (x * y)) <<< 1) + ((k02 * x) <<< 17)
            + k11 * (y * y) + ((k12 * y) <<< 17) + (k22 <<< 32);
        a = acc >>> 40;
        // gradient rows, Q.40 floored to Q.16
        g1 = (k00 * x + k01 * y + k02 * w) >>> 24;
        g2 = (k01 * x + k11 * y + k12 * w) >>> 24;
        am  = (a < 0) ? -a : a;
        g1m = (g1 < 0) ? -g1 : g1;
        g2m = (g2 < 0) ? -g2 : g2;
        num = am * am;
        den = g1m * g1m + g2m * g2m;
        r.last = last;
        if (den == 0) begin
            r.zero_den = 1'b1;
            r.distance = DIST_MAX;
        end else begin
            r.zero_den = 1'b0;
            quo = {num, 16'h0} / {16'h0, den};
            r.distance = (quo > {96'h0, DIST_MAX}) ? DIST_MAX : quo[M_TDATA_WIDTH-1:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        dist_result_t got, want;
        if (!aresetn) begin
            conic_xx <= '0;
            conic_xy <= '0;
            conic_xw <= '0;
            conic_yy <= '0;
            conic_yw <= '0;
            conic_ww <= '0;
        end else begin
            // coefficient writes, unknown indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_COEF_XX: conic_xx <= cfg_wdata;
                    CFG_COEF_XY: conic_xy <= cfg_wdata;
                    CFG_COEF_XW: conic_xw <= cfg_wdata;
                    CFG_COEF_YY: conic_yy <= cfg_wdata;
                    CFG_COEF_YW: conic_yw <= cfg_wdata;
                    CFG_COEF_WW: conic_ww <= cfg_wdata;
                    default: ;
                endcase
            end
            // point transaction, coordinates sign-extended from the used bits
            if (s_tvalid && s_tready)
                owed_distances = {owed_distances,
                                  sampson_distance($signed(s_tdata[COORD_WIDTH-1:0]),
                                                   $signed(s_tdata[32+COORD_WIDTH-1:32]),
                                                   $signed(s_tdata[64+COORD_WIDTH-1:64]),
                                                   s_tlast)};
            // result transaction
            if (m_tvalid && m_tready) begin
                got.distance = m_tdata;
                got.zero_den = m_tuser;
                got.last     = m_tlast;
                if (owed_distances.size() == 0) begin
                    report_mismatch("result with no point outstanding");
                end else begin
                    want = owed_distances.pop_front();
                    if (got.distance !== want.distance)
                        report_mismatch($sformatf("distance %h, predicted %h",
                                                  got.distance, want.distance));
                    if (got.zero_den !== want.zero_den)
                        report_mismatch($sformatf("zero_denominator %b, predicted %b",
                                                  got.zero_den, want.zero_den));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, predicted %b",
                                                  got.last, want.last));
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives the point-to-conic distance unit with directed and random points
// under a series of conics, with random gaps on both stream sides
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pcsd_pkg::*;

    localparam int DRAIN_CYCLES = PIPE_DEPTH + 12;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [31:0] ONE  = 32'h0100_0000;  // 1.0 in Q8.24
    localparam logic [31:0] PONE = 32'h0001_0000;  // 1.0 in Q16.16

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [S_TDATA_WIDTH-1:0]    s_tdata;
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [M_TDATA_WIDTH-1:0]    m_tdata;
    logic                        m_tuser;
    logic                        m_tlast;
    logic                        cfg_wr_en;
    logic [CFG_ADDR_WIDTH-1:0]   cfg_addr;
    logic [COEF_WIDTH-1:0]       cfg_wdata;
    int                          error_count;
    int                          results_owed;
    logic                        calm;
    int                          quiet_cycles;

    point_conic_sampson_distance_unit u_top (.*);

    point_conic_sampson_distance_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side backpressure
    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(0, 99) >= 29);

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL point_conic_sampson_distance_unit");
            $finish;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] w, input logic last);
        logic ready_seen;
        while (!calm && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, y, x};
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
    endtask

    // let every outstanding point come out, then let the pipe settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // writes all six entries back to back, optionally one unknown index too
    task automatic load_conic(input logic [31:0] c [6], input logic junk);
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= cfg_index_t'(i);
            cfg_wdata <= c[i];
            @(posedge aclk);
        end
        if (junk) begin
            cfg_addr  <= 3'd6 + 3'($urandom_range(0, 1));
            cfg_wdata <= $urandom;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            4:    return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 3) << 16;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef(input int spread);
        if (spread == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 4 * ONE)) - 2 * ONE);
    endfunction

    initial begin
        logic [31:0] conic [6];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        calm      = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset conic is all zero, every point has a zero denominator
        send_point(PONE, PONE, PONE, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        drain();

        // unit circle
        conic = '{ONE, 32'h0, 32'h0, ONE, 32'h0, -ONE};
        load_conic(conic, 1'b1);
        send_point(PONE, 32'h0, PONE, 1'b0);            // on the curve
        send_point(32'h0, 32'h0, 32'h0, 1'b0);          // zero gradient
        send_point(32'h0, 32'h0, PONE, 1'b0);           // center, zero gradient
        send_point(32'h0000_0001, 32'h0, 32'h0, 1'b0);  // tiny gradient, overflow
        send_point(2 * PONE, 32'h0, PONE, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFF_0000, 1'b0);
        drain();

        // most negative entries
        conic = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        load_conic(conic, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
        send_point(PONE, -PONE, PONE, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        drain();

        // most positive entries
        conic = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        load_conic(conic, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_point(-PONE, PONE, PONE, 1'b1);
        drain();

        // random conics, mostly normalized, a few full range
        for (int phase = 0; phase < 8; phase++) begin
            for (int i = 0; i < 6; i++)
                conic[i] = pick_coef((phase % 3 == 2) ? 0 : 1);
            load_conic(conic, phase[0]);
            calm = (phase == 4);
            for (int n = 0; n < 200; n++)
                send_point(pick_coord(), pick_coord(), pick_coord(),
                           $urandom_range(0, 7) == 0);
            drain();
            calm = 1'b0;
        end

        if (error_count == 0 && results_owed == 0)
            $display("PASS point_conic_sampson_distance_unit");
        else
            $display("FAIL point_conic_sampson_distance_unit");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcsd_pkg.sv
rtl/point_conic_sampson_distance_unit.sv
rtl/pcsd_checker.sv
tb/point_conic_sampson_distance_checker.sv
tb/testbench.sv
